>>> hw/rtl/rn256_pkg.sv
// Shared types and constants for the radix node256 child table.
// Used by the top level, the occupancy bitmap and the port checker.
`default_nettype none

package rn256_pkg;

    localparam int SLOT_COUNT        = 256;
    localparam int KEY_BITS          = $clog2(SLOT_COUNT);
    localparam int COUNT_BITS        = KEY_BITS + 1;
    localparam int ACTION_BITS       = 3;
    localparam int THR_BITS          = 6;
    localparam int POS_BITS          = 6;
    localparam int DEF_HANDLE_BITS   = 48;
    localparam int DEF_COMPACT_SLOTS = 48;

    localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(37);

    localparam logic [ACTION_BITS-1:0] ACT_FIND   = 3'd0;
    localparam logic [ACTION_BITS-1:0] ACT_ADD    = 3'd1;
    localparam logic [ACTION_BITS-1:0] ACT_REMOVE = 3'd2;
    localparam logic [ACTION_BITS-1:0] ACT_FIRST  = 3'd3;
    localparam logic [ACTION_BITS-1:0] ACT_LAST   = 3'd4;

    typedef logic [SLOT_COUNT-1:0] t_slots;
    typedef logic [KEY_BITS-1:0]   t_key;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEEK,
        ST_EXEC,
        ST_SCAN_RD,
        ST_SCAN_EMIT
    } t_state;

    // update of one occupancy bit
    typedef struct packed {
        logic en;
        logic val;
        t_key idx;
    } t_occ_cmd;

    // what the bitmap reports back
    typedef struct packed {
        logic bit_at;
        logic any;
        t_key lowest;
        t_key highest;
    } t_occ_stat;

endpackage

`default_nettype wire

>>> hw/rtl/rn256_occ.sv
// Occupancy bitmap of the child table: one flop per slot, cleared at reset.
// Gives the bit at a lookup index and the lowest and highest set slot. Uses rn256_pkg.
`default_nettype none

module rn256_occ (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  rn256_pkg::t_occ_cmd  i_cmd,
    input  rn256_pkg::t_key      i_look,
    output rn256_pkg::t_occ_stat o_stat
);
    import rn256_pkg::*;

    t_slots r_occ;

    // binary search over halves: eight narrowing steps
    function automatic t_key f_lowest(input t_slots v);
        t_slots w;
        t_slots m;
        t_key   idx;
        w   = v;
        idx = '0;
        for (int b = KEY_BITS - 1; b >= 0; b--) begin
            m = (t_slots'(1) << (1 << b)) - t_slots'(1);
            if ((w & m) == '0) begin
                idx[b] = 1'b1;
                w      = w >> (1 << b);
            end else begin
                w = w & m;
            end
        end
        return idx;
    endfunction

    function automatic t_key f_highest(input t_slots v);
        t_slots w;
        t_slots m;
        t_key   idx;
        w   = v;
        idx = '0;
        for (int b = KEY_BITS - 1; b >= 0; b--) begin
            m = (t_slots'(1) << (1 << b)) - t_slots'(1);
            if ((w >> (1 << b)) != '0) begin
                idx[b] = 1'b1;
                w      = w >> (1 << b);
            end else begin
                w = w & m;
            end
        end
        return idx;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.en) begin
            r_occ[i_cmd.idx] <= i_cmd.val;
        end
    end

    assign o_stat.bit_at  = r_occ[i_look];
    assign o_stat.any     = |r_occ;
    assign o_stat.lowest  = f_lowest(r_occ);
    assign o_stat.highest = f_highest(r_occ);

endmodule

`default_nettype wire

>>> hw/rtl/radix_node256_child_table.sv
// Top level of the radix node256 child table: handle memory, count and control.
// Depends on rn256_pkg and rn256_occ.
//
// Usage:
//   Requests enter on the input channel (i_in_valid / o_in_stall) with an action,
//   a key byte and a child handle. Results leave on the output channel
//   (o_out_valid / i_out_stall) from an output register, one per request, or one
//   per remaining child when a remove starts a compaction run.
//   The shrink threshold is written through i_cfg_valid / o_cfg_ready / i_cfg_data
//   while the block is idle.
// Sequencing:
//   Find, add, remove and unknown actions: the handle is read into a register, then
//   the result is registered; the next request is taken only once the block is idle.
//   First and last: an occupancy search step (ST_SEEK) comes before the read.
//   Compaction run: per child, a read step (ST_SCAN_RD) then an emit step (ST_SCAN_EMIT).
// The steps are set by the single-port handle memory with registered read.
// Reset: occupancy bitmap and count go to zero, threshold to 37; the handle
//   memory keeps its contents, masked by the cleared occupancy bits.
// Stall: a stalled result holds in the output register; the block holds its
//   current step and stalls the input until the register frees.
`default_nettype none

module radix_node256_child_table #(
    parameter int HANDLE_BITS   = rn256_pkg::DEF_HANDLE_BITS,
    parameter int COMPACT_SLOTS = rn256_pkg::DEF_COMPACT_SLOTS
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire  [rn256_pkg::ACTION_BITS-1:0]   i_action,
    input  wire  [rn256_pkg::KEY_BITS-1:0]      i_key_byte,
    input  wire  [HANDLE_BITS-1:0]              i_child_handle,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic                                o_found,
    output logic [rn256_pkg::KEY_BITS-1:0]      o_slot_key,
    output logic [HANDLE_BITS-1:0]              o_handle_out,
    output logic [rn256_pkg::POS_BITS-1:0]      o_compact_pos,
    output logic [rn256_pkg::COUNT_BITS-1:0]    o_child_count,
    output logic                                o_in_shrink,
    output logic                                o_run_last,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [rn256_pkg::THR_BITS-1:0]      i_cfg_data
);
    import rn256_pkg::*;

    logic [HANDLE_BITS-1:0] mem [SLOT_COUNT];

    t_state                 r_state, n_state;
    logic [ACTION_BITS-1:0] r_act;
    t_key                   r_key, n_key;
    logic [HANDLE_BITS-1:0] r_hdl;
    logic [HANDLE_BITS-1:0] r_rd;
    logic                   r_hit, n_hit;
    logic [COUNT_BITS-1:0]  r_count, n_count;
    logic [THR_BITS-1:0]    r_thr;
    logic [POS_BITS-1:0]    r_pos, n_pos;
    logic [THR_BITS-1:0]    r_total, n_total;

    logic                   r_out_valid, n_out_valid;
    logic                   r_found, n_found;
    t_key                   r_okey, n_okey;
    logic [HANDLE_BITS-1:0] r_ohdl, n_ohdl;
    logic [POS_BITS-1:0]    r_opos, n_opos;
    logic [COUNT_BITS-1:0]  r_ocount, n_ocount;
    logic                   r_oshrink, n_oshrink;
    logic                   r_olast, n_olast;

    logic                   in_accept;
    logic                   out_free;
    logic                   rd_en;
    t_key                   rd_addr;
    logic                   wr_en;
    t_occ_cmd               occ_cmd;
    t_occ_stat              occ_stat;
    logic [HANDLE_BITS-1:0] old_hdl;
    logic                   hdl_nz;
    logic [COUNT_BITS-1:0]  cnt_dec;
    logic                   thr_ok;
    logic                   shrink_go;
    logic                   scan_last;

    rn256_occ u_occ (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (occ_cmd),
        .i_look  (r_key),
        .o_stat  (occ_stat)
    );

    assign in_accept   = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;

    assign old_hdl   = occ_stat.bit_at ? r_rd : '0;
    assign hdl_nz    = (r_hdl != '0);
    assign cnt_dec   = r_count - COUNT_BITS'(1);
    assign thr_ok    = (r_thr != '0) && ({1'b0, r_thr} <= (THR_BITS + 1)'(COMPACT_SLOTS));
    assign shrink_go = occ_stat.bit_at && thr_ok && (cnt_dec == COUNT_BITS'(r_thr));
    assign scan_last = ({1'b0, r_pos} + (POS_BITS + 1)'(1)) == (POS_BITS + 1)'(r_total);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = (i_action == ACT_FIRST || i_action == ACT_LAST) ?
                              ST_SEEK : ST_EXEC;
                end
            end
            ST_SEEK: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_state = (r_act == ACT_REMOVE && shrink_go) ? ST_SCAN_RD : ST_IDLE;
                end
            end
            ST_SCAN_RD: begin
                n_state = ST_SCAN_EMIT;
            end
            ST_SCAN_EMIT: begin
                if (out_free) begin
                    n_state = scan_last ? ST_IDLE : ST_SCAN_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        rd_en       = 1'b0;
        rd_addr     = i_key_byte;
        wr_en       = 1'b0;
        occ_cmd     = '0;
        occ_cmd.idx = r_key;
        n_key       = r_key;
        n_hit       = r_hit;
        n_count     = r_count;
        n_pos       = r_pos;
        n_total     = r_total;
        n_out_valid = r_out_valid && i_out_stall;
        n_found     = r_found;
        n_okey      = r_okey;
        n_ohdl      = r_ohdl;
        n_opos      = r_opos;
        n_ocount    = r_ocount;
        n_oshrink   = r_oshrink;
        n_olast     = r_olast;

        unique case (r_state)
            ST_IDLE: begin
                rd_en = in_accept;
                n_key = i_key_byte;
            end
            ST_SEEK: begin
                rd_en   = 1'b1;
                rd_addr = (r_act == ACT_FIRST) ? occ_stat.lowest : occ_stat.highest;
                n_key   = rd_addr;
                n_hit   = occ_stat.any;
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_opos      = '0;
                    n_oshrink   = 1'b0;
                    n_olast     = 1'b1;
                    n_okey      = r_key;
                    case (r_act)
                        ACT_FIND: begin
                            n_found = occ_stat.bit_at;
                            n_ohdl  = old_hdl;
                        end
                        ACT_ADD: begin
                            wr_en       = 1'b1;
                            occ_cmd.en  = 1'b1;
                            occ_cmd.val = hdl_nz;
                            if (!occ_stat.bit_at && hdl_nz) begin
                                n_count = r_count + COUNT_BITS'(1);
                            end else if (occ_stat.bit_at && !hdl_nz) begin
                                n_count = cnt_dec;
                            end
                            n_found = hdl_nz;
                            n_ohdl  = r_hdl;
                        end
                        ACT_REMOVE: begin
                            occ_cmd.en  = 1'b1;
                            occ_cmd.val = 1'b0;
                            if (occ_stat.bit_at) begin
                                n_count = cnt_dec;
                            end
                            n_found = occ_stat.bit_at;
                            n_ohdl  = old_hdl;
                            if (shrink_go) begin
                                // no result for the remove itself; the run follows
                                n_out_valid = r_out_valid && i_out_stall;
                                n_count     = '0;
                                n_pos       = '0;
                                n_total     = r_thr;
                            end
                        end
                        ACT_FIRST, ACT_LAST: begin
                            n_found = r_hit;
                            n_okey  = r_hit ? r_key : '0;
                            n_ohdl  = r_hit ? r_rd : '0;
                        end
                        default: begin
                            n_found = 1'b0;
                            n_okey  = '0;
                            n_ohdl  = '0;
                        end
                    endcase
                    n_ocount = n_count;
                end
            end
            ST_SCAN_RD: begin
                // fetch the lowest remaining child and drop its bit
                rd_en       = 1'b1;
                rd_addr     = occ_stat.lowest;
                n_key       = occ_stat.lowest;
                occ_cmd.en  = 1'b1;
                occ_cmd.val = 1'b0;
                occ_cmd.idx = occ_stat.lowest;
            end
            ST_SCAN_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_found     = 1'b1;
                    n_okey      = r_key;
                    n_ohdl      = r_rd;
                    n_opos      = r_pos;
                    n_ocount    = '0;
                    n_oshrink   = 1'b1;
                    n_olast     = scan_last;
                    n_pos       = r_pos + POS_BITS'(1);
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[r_key] <= r_hdl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_thr       <= THR_RESET;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_total     <= '0;
            r_hit       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
            r_total     <= n_total;
            r_hit       <= n_hit;
            if (i_cfg_valid && o_cfg_ready) begin
                r_thr <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_act <= i_action;
            r_hdl <= i_child_handle;
        end
        r_key     <= n_key;
        r_found   <= n_found;
        r_okey    <= n_okey;
        r_ohdl    <= n_ohdl;
        r_opos    <= n_opos;
        r_ocount  <= n_ocount;
        r_oshrink <= n_oshrink;
        r_olast   <= n_olast;
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_slot_key    = r_okey;
    assign o_handle_out  = r_ohdl;
    assign o_compact_pos = r_opos;
    assign o_child_count = r_ocount;
    assign o_in_shrink   = r_oshrink;
    assign o_run_last    = r_olast;

endmodule

`default_nettype wire

>>> hw/rtl/rn256_chk.sv
// Port-level checker for the radix node256 child table, bound to the top level.
// Depends on rn256_pkg for field widths.
`default_nettype none

module rn256_chk #(
    parameter int HANDLE_BITS = rn256_pkg::DEF_HANDLE_BITS
) (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              o_out_valid,
    input wire                              i_out_stall,
    input wire                              o_found,
    input wire [rn256_pkg::KEY_BITS-1:0]    o_slot_key,
    input wire [HANDLE_BITS-1:0]            o_handle_out,
    input wire [rn256_pkg::POS_BITS-1:0]    o_compact_pos,
    input wire [rn256_pkg::COUNT_BITS-1:0]  o_child_count,
    input wire                              o_in_shrink,
    input wire                              o_run_last
);
    import rn256_pkg::*;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_slot_key)
                                       && $stable(o_handle_out) && $stable(o_run_last))
        else $error("stalled result changed");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_in_shrink |-> o_run_last && (o_compact_pos == '0))
        else $error("ordinary result not marked last or has a position");

    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_in_shrink |-> o_found && (o_child_count == '0))
        else $error("compaction result without child or with nonzero count");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> (o_handle_out == '0))
        else $error("empty result carries a handle");

endmodule

bind radix_node256_child_table rn256_chk #(.HANDLE_BITS(HANDLE_BITS)) u_rn256_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_found       (o_found),
    .o_slot_key    (o_slot_key),
    .o_handle_out  (o_handle_out),
    .o_compact_pos (o_compact_pos),
    .o_child_count (o_child_count),
    .o_in_shrink   (o_in_shrink),
    .o_run_last    (o_run_last)
);

`default_nettype wire

>>> tb/child_table_checker.sv
// Port checker for the radix node256 child table: tracks the slot store,
// the child count and the shrink threshold, and scores every result in order.
// Depends on rn256_pkg; instantiated next to the block by tb.
module child_table_checker #(
    parameter int HANDLE_BITS   = rn256_pkg::DEF_HANDLE_BITS,
    parameter int COMPACT_SLOTS = rn256_pkg::DEF_COMPACT_SLOTS
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    input  wire                                 i_in_stall,
    input  wire  [rn256_pkg::ACTION_BITS-1:0]   i_action,
    input  wire  [rn256_pkg::KEY_BITS-1:0]      i_key_byte,
    input  wire  [HANDLE_BITS-1:0]              i_child_handle,
    input  wire                                 i_out_valid,
    input  wire                                 i_out_stall,
    input  wire                                 i_found,
    input  wire  [rn256_pkg::KEY_BITS-1:0]      i_slot_key,
    input  wire  [HANDLE_BITS-1:0]              i_handle_out,
    input  wire  [rn256_pkg::POS_BITS-1:0]      i_compact_pos,
    input  wire  [rn256_pkg::COUNT_BITS-1:0]    i_child_count,
    input  wire                                 i_in_shrink,
    input  wire                                 i_run_last,
    input  wire                                 i_cfg_valid,
    input  wire                                 i_cfg_ready,
    input  wire  [rn256_pkg::THR_BITS-1:0]      i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rn256_pkg::*;

    typedef struct {
        logic                   found;
        t_key                   slot_key;
        logic [HANDLE_BITS-1:0] handle;
        logic [POS_BITS-1:0]    pos;
        logic [COUNT_BITS-1:0]  count;
        logic                   shrink;
        logic                   last;
    } t_child_result;

    t_child_result          child_results_q[$];
    logic [HANDLE_BITS-1:0] slot_handles[SLOT_COUNT];
    int unsigned            live_children;
    logic [THR_BITS-1:0]    shrink_thr;
    int                     mismatches;

    function automatic void push_child_result(input logic found, input t_key key,
                                              input logic [HANDLE_BITS-1:0] handle,
                                              input int pos, input logic shrink,
                                              input logic last);
        t_child_result r;
        r.found    = found;
        r.slot_key = key;
        r.handle   = handle;
        r.pos      = POS_BITS'(pos);
        r.count    = COUNT_BITS'(live_children);
        r.shrink   = shrink;
        r.last     = last;
        child_results_q.push_back(r);
    endfunction

    // Apply one request to the shadow table and queue the results it causes.
    function automatic void apply_table_request(input logic [ACTION_BITS-1:0] act,
                                                input t_key key,
                                                input logic [HANDLE_BITS-1:0] handle);
        logic [HANDLE_BITS-1:0] prior;
        logic                   hit;
        logic                   compacted;
        int                     total;
        int                     emitted;
        int                     i;
        prior     = slot_handles[key];
        hit       = 1'b0;
        compacted = 1'b0;
        case (act)
            ACT_FIND: begin
                push_child_result(prior != '0, key, prior, 0, 1'b0, 1'b1);
            end
            ACT_ADD: begin
                if (prior == '0 && handle != '0) begin
                    live_children++;
                end else if (prior != '0 && handle == '0) begin
                    live_children--;
                end
                slot_handles[key] = handle;
                push_child_result(handle != '0, key, handle, 0, 1'b0, 1'b1);
            end
            ACT_REMOVE: begin
                slot_handles[key] = '0;
                if (prior != '0) begin
                    live_children--;
                    if (shrink_thr >= 1 && shrink_thr <= COMPACT_SLOTS &&
                        live_children == shrink_thr) begin
                        // emit survivors in key order, then empty the table
                        compacted     = 1'b1;
                        total         = live_children;
                        live_children = 0;
                        emitted       = 0;
                        for (i = 0; i < SLOT_COUNT; i++) begin
                            if (slot_handles[i] != '0) begin
                                push_child_result(1'b1, t_key'(i), slot_handles[i], emitted,
                                                  1'b1, emitted + 1 == total);
                                emitted++;
                                slot_handles[i] = '0;
                            end
                        end
                    end
                end
                if (!compacted) begin
                    push_child_result(prior != '0, key, prior, 0, 1'b0, 1'b1);
                end
            end
            ACT_FIRST: begin
                for (i = 0; i < SLOT_COUNT && !hit; i++) begin
                    if (slot_handles[i] != '0) begin
                        hit = 1'b1;
                        push_child_result(1'b1, t_key'(i), slot_handles[i], 0, 1'b0, 1'b1);
                    end
                end
                if (!hit) begin
                    push_child_result(1'b0, '0, '0, 0, 1'b0, 1'b1);
                end
            end
            ACT_LAST: begin
                for (i = SLOT_COUNT - 1; i >= 0 && !hit; i--) begin
                    if (slot_handles[i] != '0) begin
                        hit = 1'b1;
                        push_child_result(1'b1, t_key'(i), slot_handles[i], 0, 1'b0, 1'b1);
                    end
                end
                if (!hit) begin
                    push_child_result(1'b0, '0, '0, 0, 1'b0, 1'b1);
                end
            end
            default: begin
                push_child_result(1'b0, '0, '0, 0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    function automatic void score_child_result();
        t_child_result e;
        if (child_results_q.size() == 0) begin
            if (mismatches < 10) begin
                $display("%0t: result with none pending: found=%0d key=%0d handle=%h",
                         $time, i_found, i_slot_key, i_handle_out);
            end
            mismatches++;
            return;
        end
        e = child_results_q.pop_front();
        if (i_found !== e.found || i_slot_key !== e.slot_key || i_handle_out !== e.handle ||
            i_compact_pos !== e.pos || i_child_count !== e.count ||
            i_in_shrink !== e.shrink || i_run_last !== e.last) begin
            if (mismatches < 10) begin
                $display("%0t: result mismatch, expected found=%0d key=%0d handle=%h pos=%0d",
                         $time, e.found, e.slot_key, e.handle, e.pos);
                $display("    count=%0d shrink=%0d last=%0d; got found=%0d key=%0d handle=%h",
                         e.count, e.shrink, e.last, i_found, i_slot_key, i_handle_out);
                $display("    pos=%0d count=%0d shrink=%0d last=%0d",
                         i_compact_pos, i_child_count, i_in_shrink, i_run_last);
            end
            mismatches++;
        end
    endfunction

    initial begin
        mismatches = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOT_COUNT; k++) begin
                slot_handles[k] = '0;
            end
            live_children = 0;
            shrink_thr    = THR_RESET;
            child_results_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                shrink_thr = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                score_child_result();
            end
            if (i_in_valid && !i_in_stall) begin
                apply_table_request(i_action, i_key_byte, i_child_handle);
            end
        end
        o_pending    <= child_results_q.size();
        o_fail_count <= mismatches;
    end

endmodule

>>> tb/tb.sv
// Testbench top for radix_node256_child_table: clock, reset, request and
// threshold stimulus, output stall, and the verdict.
// Depends on rn256_pkg, the block itself and child_table_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rn256_pkg::*;

    localparam int HANDLE_BITS    = DEF_HANDLE_BITS;
    localparam int COMPACT_SLOTS  = DEF_COMPACT_SLOTS;
    localparam int RANDOM_ITEMS   = 30;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES   = 8;

    localparam logic [ACTION_BITS-1:0] ACT_SPARE_LO  = 3'd5;
    localparam logic [ACTION_BITS-1:0] ACT_SPARE_MID = 3'd6;
    localparam logic [ACTION_BITS-1:0] ACT_SPARE_HI  = 3'd7;

    localparam logic [THR_BITS-1:0] THR_OFF  = '0;
    localparam logic [THR_BITS-1:0] THR_ONE  = THR_BITS'(1);
    localparam logic [THR_BITS-1:0] THR_FULL = THR_BITS'(COMPACT_SLOTS);
    localparam logic [THR_BITS-1:0] THR_TOP  = '1;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [ACTION_BITS-1:0]  in_action = '0;
    t_key                    in_key = '0;
    logic [HANDLE_BITS-1:0]  in_handle = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    found;
    t_key                    slot_key;
    logic [HANDLE_BITS-1:0]  handle_out;
    logic [POS_BITS-1:0]     compact_pos;
    logic [COUNT_BITS-1:0]   child_count;
    logic                    in_shrink;
    logic                    run_last;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [THR_BITS-1:0]     cfg_data = '0;
    int                      fail_count;
    int                      pending;

    // stimulus-side view of which slots hold a child
    t_slots                  key_live = '0;
    int                      live_count = 0;
    logic [THR_BITS-1:0]     stim_thr = THR_RESET;
    logic                    run_seen = 1'b0;
    int                      tx_idle_pct = 0;
    int                      rx_idle_pct = 0;
    logic                    hold_armed = 1'b0;

    radix_node256_child_table #(
        .HANDLE_BITS  (HANDLE_BITS),
        .COMPACT_SLOTS(COMPACT_SLOTS)
    ) i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_action      (in_action),
        .i_key_byte    (in_key),
        .i_child_handle(in_handle),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_found       (found),
        .o_slot_key    (slot_key),
        .o_handle_out  (handle_out),
        .o_compact_pos (compact_pos),
        .o_child_count (child_count),
        .o_in_shrink   (in_shrink),
        .o_run_last    (run_last),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    child_table_checker #(
        .HANDLE_BITS  (HANDLE_BITS),
        .COMPACT_SLOTS(COMPACT_SLOTS)
    ) i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_action      (in_action),
        .i_key_byte    (in_key),
        .i_child_handle(in_handle),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_found       (found),
        .i_slot_key    (slot_key),
        .i_handle_out  (handle_out),
        .i_compact_pos (compact_pos),
        .i_child_count (child_count),
        .i_in_shrink   (in_shrink),
        .i_run_last    (run_last),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Output side: random stall, plus one long hold once the random part starts.
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else begin
                out_stall = rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct;
            end
        end
    end

    function automatic logic [HANDLE_BITS-1:0] rand_handle();
        logic [HANDLE_BITS-1:0] h;
        case ($urandom_range(0, 7))
            0:       h = '1;
            1:       h = HANDLE_BITS'(1) << $urandom_range(0, HANDLE_BITS - 1);
            default: h = HANDLE_BITS'({$urandom(), $urandom()});
        endcase
        if (h == '0) begin
            h = HANDLE_BITS'(1);
        end
        return h;
    endfunction

    function automatic t_key pick_live_key();
        t_key k;
        k = t_key'($urandom_range(0, SLOT_COUNT - 1));
        if (live_count == 0) begin
            return k;
        end
        while (!key_live[k]) begin
            k = k + 1'b1;
        end
        return k;
    endfunction

    function automatic t_key pick_free_key();
        t_key k;
        k = t_key'($urandom_range(0, SLOT_COUNT - 1));
        while (key_live[k]) begin
            k = k + 1'b1;
        end
        return k;
    endfunction

    // Track occupancy so the stimulus can steer toward compaction runs.
    function automatic void note_table_effect(input logic [ACTION_BITS-1:0] act,
                                              input t_key key,
                                              input logic [HANDLE_BITS-1:0] h);
        case (act)
            ACT_ADD: begin
                if (h != '0 && !key_live[key]) begin
                    key_live[key] = 1'b1;
                    live_count++;
                end else if (h == '0 && key_live[key]) begin
                    key_live[key] = 1'b0;
                    live_count--;
                end
            end
            ACT_REMOVE: begin
                if (key_live[key]) begin
                    key_live[key] = 1'b0;
                    live_count--;
                    if (stim_thr >= 1 && stim_thr <= COMPACT_SLOTS && live_count == stim_thr) begin
                        key_live   = '0;
                        live_count = 0;
                        run_seen   = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_request(input logic [ACTION_BITS-1:0] act, input t_key key,
                                input logic [HANDLE_BITS-1:0] h);
        @(negedge clk);
        while (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        in_action = act;
        in_key    = key;
        in_handle = h;
        do @(posedge clk); while (in_stall);
        note_table_effect(act, key, h);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THR_BITS-1:0] thr);
        drain_results();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = thr;
        do @(posedge clk); while (!cfg_ready);
        stim_thr = thr;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic issue_random_request(input int target);
        int r;
        t_key k;
        r = $urandom_range(0, 99);
        if (r < 50 && live_count < target) begin
            send_request(ACT_ADD, pick_free_key(), rand_handle());
        end else if (r < 60 || (r < 50 && live_count >= target)) begin
            send_request(ACT_REMOVE, pick_live_key(), rand_handle());
        end else if (r < 70) begin
            k = $urandom_range(0, 1) ? pick_live_key() : t_key'($urandom_range(0, 255));
            send_request(ACT_FIND, k, rand_handle());
        end else if (r < 78) begin
            send_request($urandom_range(0, 1) ? ACT_FIRST : ACT_LAST,
                         t_key'($urandom_range(0, 255)), rand_handle());
        end else if (r < 85) begin
            send_request(ACT_ADD, pick_live_key(),
                         $urandom_range(0, 3) == 0 ? '0 : rand_handle());
        end else if (r < 89) begin
            send_request(ACTION_BITS'(ACT_SPARE_LO +
                                      $urandom_range(0, ACT_SPARE_HI - ACT_SPARE_LO)),
                         t_key'($urandom_range(0, 255)), rand_handle());
        end else if (r < 94) begin
            send_request(ACT_REMOVE, t_key'($urandom_range(0, 255)), rand_handle());
        end else begin
            send_request(ACT_ADD, t_key'($urandom_range(0, 255)), '0);
        end
    endtask

    initial begin
        int                  random_items;
        int                  round_items;
        int                  target;
        int                  r;
        logic [THR_BITS-1:0] thr;

        random_items = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, extremes of key and handle, overwrite, clear,
        // remove of an empty slot, unused action codes; no compaction here.
        write_threshold(THR_OFF);
        send_request(ACT_FIND, 8'd0, '0);
        send_request(ACT_FIRST, 8'd0, '0);
        send_request(ACT_LAST, 8'd255, '1);
        send_request(ACT_ADD, 8'd0, '1);
        send_request(ACT_ADD, 8'd255, HANDLE_BITS'(1));
        send_request(ACT_ADD, 8'd128, '0);
        send_request(ACT_FIND, 8'd0, '0);
        send_request(ACT_FIND, 8'd255, '0);
        send_request(ACT_FIRST, 8'd0, '0);
        send_request(ACT_LAST, 8'd0, '0);
        send_request(ACT_ADD, 8'd255, HANDLE_BITS'(1) << (HANDLE_BITS - 1));
        send_request(ACT_REMOVE, 8'd7, '1);
        send_request(ACT_ADD, 8'd0, '0);
        send_request(ACT_FIRST, 8'd0, '0);
        send_request(ACT_REMOVE, 8'd255, '0);
        send_request(ACT_LAST, 8'd0, '0);
        send_request(ACT_SPARE_LO, 8'd255, '1);
        send_request(ACT_SPARE_MID, 8'd85, rand_handle());
        send_request(ACT_SPARE_HI, 8'd0, '0);

        // Smallest compaction run: one survivor.
        write_threshold(THR_ONE);
        send_request(ACT_ADD, 8'd3, rand_handle());
        send_request(ACT_ADD, 8'd200, rand_handle());
        send_request(ACT_REMOVE, 8'd200, '0);
        send_request(ACT_FIND, 8'd3, '0);

        // Largest compaction run, back to back with no idling.
        write_threshold(THR_FULL);
        send_request(ACT_ADD, 8'd0, rand_handle());
        send_request(ACT_ADD, 8'd255, rand_handle());
        while (live_count < COMPACT_SLOTS + 1) begin
            send_request(ACT_ADD, pick_free_key(), rand_handle());
        end
        send_request(ACT_REMOVE, pick_live_key(), '0);

        // Random rounds, each under its own threshold.
        tx_idle_pct = 19;
        rx_idle_pct = 19;
        write_threshold(THR_TOP);
        hold_armed = 1'b1;
        for (int i = 0; i < 20; i++) begin
            issue_random_request(10);
            random_items++;
        end
        while (random_items < RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
                thr = THR_OFF;
            end else if (r == 1) begin
                thr = THR_BITS'($urandom_range(COMPACT_SLOTS + 1, THR_TOP));
            end else if (r == 2) begin
                thr = THR_BITS'($urandom_range(7, 12));
            end else begin
                thr = THR_BITS'($urandom_range(1, 6));
            end
            write_threshold(thr);
            target = (thr >= 1 && thr <= COMPACT_SLOTS) ? thr + 1 : $urandom_range(4, 10);
            run_seen = 1'b0;
            round_items = 0;
            while (!run_seen && round_items < 4 * target + 12) begin
                issue_random_request(target);
                round_items++;
                random_items++;
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
